// ===== design/cubic_hermite_segment_eval_assert.svh =====
// Assertion macros used by the checker of the Hermite segment evaluator.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef CUBIC_HERMITE_SEGMENT_EVAL_ASSERT_SVH
`define CUBIC_HERMITE_SEGMENT_EVAL_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define CHSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chse check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define CHSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chse check failed");

`endif

// ===== design/chse_pkg.sv =====
// Shared widths, register indexes and bundle types of the Hermite segment evaluator.
// Depends on nothing; the evaluator design modules import it.
package chse_pkg;

  localparam int unsigned QW     = 32;        // query, slope, point width
  localparam int unsigned LW     = 32;        // limb width of the Horner multipliers
  localparam int unsigned UW     = LW + 1;    // offset from the left endpoint
  localparam int unsigned FW     = 35;        // serial multiplier factor width
  localparam int unsigned SW     = 136;       // serial multiplier accumulator width
  localparam int unsigned CNTW   = 6;         // serial multiplier bit counter
  localparam int unsigned H2W    = 66;        // h^2
  localparam int unsigned H3W    = 100;       // h^3
  localparam int unsigned AW     = 68;        // A and B terms
  localparam int unsigned C2W    = 100;       // h*A
  localparam int unsigned C1W    = 128;       // m1*h^3
  localparam int unsigned C0W    = 144;       // y1*h^3*2^16
  localparam int unsigned DENW   = 113;       // h^3*2^16
  localparam int unsigned RW     = 146;       // division remainder
  localparam int unsigned LIMBS  = 5;         // limbs of the wide Horner operand
  localparam int unsigned WW     = LIMBS * LW;
  localparam int unsigned NW     = 168;       // Horner sums and numerator
  localparam int unsigned QB     = 32;        // quotient bits
  localparam int unsigned CFG_AW = 5;         // APB address width

  localparam logic [QW-1:0] Y_MAX = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] Y_MIN = 32'h8000_0000;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_START_X     = 3'd0;
  localparam reg_idx_t REG_START_Y     = 3'd1;
  localparam reg_idx_t REG_END_X       = 3'd2;
  localparam reg_idx_t REG_END_Y       = 3'd3;
  localparam reg_idx_t REG_START_SLOPE = 3'd4;
  localparam reg_idx_t REG_END_SLOPE   = 3'd5;

  typedef struct packed {
    logic signed [QW-1:0] start_x;
    logic signed [QW-1:0] start_y;
    logic signed [QW-1:0] end_x;
    logic signed [QW-1:0] end_y;
    logic signed [QW-1:0] start_slope;
    logic signed [QW-1:0] end_slope;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    start_x:     32'sd0,
    start_y:     32'sd0,
    end_x:       32'sd65536,
    end_y:       32'sd0,
    start_slope: 32'sd0,
    end_slope:   32'sd0
  };

  // Horner coefficients and divider constants derived from the configuration
  typedef struct packed {
    logic signed [AW-1:0]  c3;
    logic signed [C2W-1:0] c2;
    logic signed [C1W-1:0] c1;
    logic signed [C0W-1:0] c0;
    logic [DENW-1:0]       den;
    logic [RW-1:0]         sat_pos;
    logic [RW-1:0]         sat_neg;
  } coef_t;

endpackage

// ===== design/chse_coef.sv =====
// Coefficient sequencer: derives Horner coefficients and divider constants
// with one shift-add multiplier. Depends on chse_pkg.
module chse_coef (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  chse_pkg::cfg_t cfg_i,
  output chse_pkg::coef_t coef_o,
  output logic           busy_o
);
  import chse_pkg::*;

  typedef enum logic [2:0] {
    ST_H2, ST_H3, ST_C1, ST_C0, ST_P, ST_Q, ST_C2, ST_IDLE
  } state_e;

  state_e                state_q;
  logic [CNTW-1:0]       cnt_q;
  logic signed [SW-1:0]  xs_q, acc_q, acc_next, x_sel;
  logic signed [FW-1:0]  fs_q, f_sel;
  logic signed [UW-1:0]  h, d;
  logic signed [H2W-1:0] h2_q;
  logic signed [H3W-1:0] h3_q;
  logic signed [AW-1:0]  a_q, b_q;
  logic signed [C2W-1:0] c2_q;
  logic signed [C1W-1:0] c1_q;
  logic signed [C0W-1:0] c0_q;
  logic [DENW-1:0]       den_q;
  logic [RW-1:0]         sat_pos_q, sat_neg_q;
  logic                  last;

  assign h    = UW'(cfg_i.end_x) - UW'(cfg_i.start_x);
  assign d    = UW'(cfg_i.end_y) - UW'(cfg_i.start_y);
  assign last = (cnt_q == CNTW'(FW));

  always_comb begin
    unique case (state_q)
      ST_H2:   begin x_sel = SW'(h);    f_sel = FW'(h); end
      ST_H3:   begin x_sel = SW'(h2_q); f_sel = FW'(h); end
      ST_C1:   begin x_sel = SW'(h3_q); f_sel = FW'(cfg_i.start_slope); end
      ST_C0:   begin x_sel = SW'(h3_q); f_sel = FW'(cfg_i.start_y); end
      ST_P:    begin
        x_sel = SW'(h);
        f_sel = (FW'(cfg_i.start_slope) <<< 1) + FW'(cfg_i.end_slope);
      end
      ST_Q:    begin
        x_sel = SW'(h);
        f_sel = FW'(cfg_i.start_slope) + FW'(cfg_i.end_slope);
      end
      ST_C2:   begin x_sel = SW'(a_q);  f_sel = FW'(h); end
      ST_IDLE: begin x_sel = '0;        f_sel = '0; end
    endcase
  end

  // top factor bit carries negative weight
  always_comb begin
    if (fs_q[0]) begin
      acc_next = last ? (acc_q - xs_q) : (acc_q + xs_q);
    end else begin
      acc_next = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_H2;
      cnt_q   <= '0;
    end else if (start_i) begin
      state_q <= ST_H2;
      cnt_q   <= '0;
    end else if (state_q != ST_IDLE) begin
      if (last) begin
        cnt_q   <= '0;
        state_q <= state_e'(state_q + 3'd1);
      end else begin
        cnt_q <= cnt_q + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q == '0) begin
      xs_q  <= x_sel;
      fs_q  <= f_sel;
      acc_q <= '0;
    end else begin
      xs_q  <= xs_q <<< 1;
      fs_q  <= fs_q >>> 1;
      acc_q <= acc_next;
    end
    if (last) begin
      unique case (state_q)
        ST_H2: h2_q <= H2W'(acc_next);
        ST_H3: begin
          h3_q      <= H3W'(acc_next);
          den_q     <= DENW'(acc_next <<< 16);
          sat_pos_q <= RW'(acc_next) <<< 48;
          sat_neg_q <= (RW'(acc_next) <<< 48) + (RW'(acc_next) <<< 17);
        end
        ST_C1: c1_q <= C1W'(acc_next);
        ST_C0: c0_q <= C0W'(acc_next) <<< 16;
        ST_P:  a_q  <= (AW'(d) <<< 16) + (AW'(d) <<< 17) - AW'(acc_next);
        ST_Q:  b_q  <= AW'(acc_next) - (AW'(d) <<< 17);
        ST_C2: c2_q <= C2W'(acc_next);
        ST_IDLE: begin
        end
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign coef_o = '{
    c3: b_q, c2: c2_q, c1: c1_q, c0: c0_q,
    den: den_q, sat_pos: sat_pos_q, sat_neg: sat_neg_q
  };

endmodule

// ===== design/chse_hstep.sv =====
// One Horner step, sum = u*w + c, as three register stages of limb products.
// Depends on chse_pkg.
module chse_hstep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [chse_pkg::UW-1:0] u_i,
  input  logic signed [chse_pkg::WW-1:0] w_i,
  input  logic signed [chse_pkg::NW-1:0] c_i,
  output logic                        valid_o,
  output logic signed [chse_pkg::UW-1:0] u_o,
  output logic signed [chse_pkg::NW-1:0] sum_o
);
  import chse_pkg::*;

  logic signed [UW-1:0]   limb [LIMBS];
  logic signed [2*UW-1:0] pp_d [LIMBS];
  logic signed [2*UW-1:0] pp_q [LIMBS];
  logic signed [NW-1:0]   lo_q, hi_q, sum_q;
  logic signed [UW-1:0]   u1_q, u2_q, u3_q;
  logic                   v1_q, v2_q, v3_q;

  // low limbs unsigned, top limb carries the sign
  always_comb begin
    for (int k = 0; k < LIMBS; k++) begin
      if (k == LIMBS - 1) begin
        limb[k] = {w_i[WW-1], w_i[k*LW +: LW]};
      end else begin
        limb[k] = {1'b0, w_i[k*LW +: LW]};
      end
      pp_d[k] = limb[k] * u_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < LIMBS; k++) begin
        pp_q[k] <= pp_d[k];
      end
      u1_q  <= u_i;
      lo_q  <= NW'(pp_q[0]) + (NW'(pp_q[1]) <<< LW) + c_i;
      hi_q  <= NW'(pp_q[2]) + (NW'(pp_q[3]) <<< LW) + (NW'(pp_q[4]) <<< (2*LW));
      u2_q  <= u1_q;
      sum_q <= lo_q + (hi_q <<< (2*LW));
      u3_q  <= u2_q;
    end
  end

  assign valid_o = v3_q;
  assign u_o     = u3_q;
  assign sum_o   = sum_q;

endmodule

// ===== design/chse_div.sv =====
// Rounding divide of the numerator by h^3*2^16, one quotient bit per stage,
// then saturation or error zeroing and the output register. Depends on chse_pkg.
module chse_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [chse_pkg::NW-1:0] num_i,
  input  chse_pkg::coef_t              coef_i,
  input  logic                         err_i,
  output logic                         valid_o,
  output logic [chse_pkg::QW-1:0]      y_o,
  output logic                         sat_o,
  output logic                         err_o
);
  import chse_pkg::*;

  logic [NW-1:0]  mag, ra_q;
  logic           va_q, nega_q;
  logic [RW-1:0]  r_q   [QB+1];
  logic [RW-1:0]  r_d   [QB+1];
  logic [QB-1:0]  q_q   [QB+1];
  logic [QB-1:0]  q_d   [QB+1];
  logic           neg_q [QB+1];
  logic           sat_q [QB+1];
  logic [QB:0]    v_q;
  logic [RW-1:0]  den_sh [QB+1];
  logic [QW-1:0]  y_d, y_q;
  logic           so_q, eo_q, vo_q;

  assign mag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);

  always_comb begin
    r_d[0]    = ra_q[RW-1:0];
    q_d[0]    = '0;
    den_sh[0] = '0;
    for (int s = 1; s <= QB; s++) begin
      den_sh[s] = RW'({coef_i.den, 1'b0}) << (QB - s);
      q_d[s]    = q_q[s-1];
      if (r_q[s-1] >= den_sh[s]) begin
        r_d[s]          = r_q[s-1] - den_sh[s];
        q_d[s][QB - s]  = 1'b1;
      end else begin
        r_d[s] = r_q[s-1];
      end
    end
  end

  always_comb begin
    if (err_i) begin
      y_d = '0;
    end else if (sat_q[QB]) begin
      y_d = neg_q[QB] ? Y_MIN : Y_MAX;
    end else begin
      y_d = neg_q[QB] ? (QW'(0) - q_q[QB]) : q_q[QB];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      v_q  <= '0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      v_q  <= {v_q[QB-1:0], va_q};
      vo_q <= v_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // 2|N| + D, so the floor of the quotient by 2D rounds ties away from zero
      ra_q     <= (mag << 1) + NW'(coef_i.den);
      nega_q   <= num_i[NW-1];
      r_q[0]   <= r_d[0];
      q_q[0]   <= q_d[0];
      neg_q[0] <= nega_q;
      sat_q[0] <= nega_q ? (ra_q >= NW'(coef_i.sat_neg)) : (ra_q >= NW'(coef_i.sat_pos));
      for (int s = 1; s <= QB; s++) begin
        r_q[s]   <= r_d[s];
        q_q[s]   <= q_d[s];
        neg_q[s] <= neg_q[s-1];
        sat_q[s] <= sat_q[s-1];
      end
      y_q  <= y_d;
      so_q <= sat_q[QB] & ~err_i;
      eo_q <= err_i;
    end
  end

  assign valid_o = vo_q;
  assign y_o     = y_q;
  assign sat_o   = so_q;
  assign err_o   = eo_q;

endmodule

// ===== design/cubic_hermite_segment_eval.sv =====
// Top level of the cubic Hermite segment evaluator: APB registers, query
// pipeline and output register. Depends on chse_pkg, chse_coef, chse_hstep, chse_div.
//
//   channel   group     fields (low bit up)                     direction
//   query     s_axis_*  tdata: query_x[31:0]                    in
//   result    m_axis_*  tdata: curve_y[31:0]                    out
//                       tuser: saturated[0], config_error[1]
//   config    APB       regs 0..5 at byte address 4*i           in/out
//
// The pipeline has one offset stage, three Horner steps of three stages each,
// two divider setup stages, 32 one-bit divide stages and the output register.
// One item is accepted per cycle while the sequencer is idle; the whole pipeline
// holds while a result waits. After reset and every register write the coefficient
// sequencer runs seven shift-add products in turn; s_axis_tready stays low then.
// Reset is asynchronous, active low, and clears valid bits and sequencer state.
module cubic_hermite_segment_eval (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,   // query_x[31:0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,   // curve_y[31:0]
  output logic [1:0]                  m_axis_tuser,   // saturated[0], config_error[1]
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [chse_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import chse_pkg::*;

  cfg_t                 cfg_q;
  coef_t                coef;
  reg_idx_t             idx;
  logic                 wr, busy, adv, err;
  logic                 v0_q, v1, v2, v3;
  logic signed [UW-1:0] u0_q, u1, u2;
  logic signed [NW-1:0] t2, t1, num;
  logic                 sat, cerr;
  logic [QW-1:0]        y;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[CFG_AW-1:2];

  // Register file; a write restarts the coefficient sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_START_X:     cfg_q.start_x     <= pwdata;
        REG_START_Y:     cfg_q.start_y     <= pwdata;
        REG_END_X:       cfg_q.end_x       <= pwdata;
        REG_END_Y:       cfg_q.end_y       <= pwdata;
        REG_START_SLOPE: cfg_q.start_slope <= pwdata;
        REG_END_SLOPE:   cfg_q.end_slope   <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_X:     prdata = cfg_q.start_x;
      REG_START_Y:     prdata = cfg_q.start_y;
      REG_END_X:       prdata = cfg_q.end_x;
      REG_END_Y:       prdata = cfg_q.end_y;
      REG_START_SLOPE: prdata = cfg_q.start_slope;
      REG_END_SLOPE:   prdata = cfg_q.end_slope;
      default:         prdata = '0;
    endcase
  end

  // a segment with start_x not below end_x has no valid cubic
  assign err = (cfg_q.start_x >= cfg_q.end_x);

  chse_coef u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(wr),
    .cfg_i  (cfg_q),
    .coef_o (coef),
    .busy_o (busy)
  );

  // Advance everything together unless the output item is stuck
  assign adv           = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = adv & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid & s_axis_tready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u0_q <= UW'($signed(s_axis_tdata)) - UW'(cfg_q.start_x);
    end
  end

  // N = C0 + u*(C1 + u*(C2 + u*C3))
  chse_hstep u_step3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(v0_q),
    .u_i    (u0_q),
    .w_i    (WW'(coef.c3)),
    .c_i    (NW'(coef.c2)),
    .valid_o(v1),
    .u_o    (u1),
    .sum_o  (t2)
  );

  chse_hstep u_step2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(v1),
    .u_i    (u1),
    .w_i    (t2[WW-1:0]),
    .c_i    (NW'(coef.c1)),
    .valid_o(v2),
    .u_o    (u2),
    .sum_o  (t1)
  );

  chse_hstep u_step1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(v2),
    .u_i    (u2),
    .w_i    (t1[WW-1:0]),
    .c_i    (NW'(coef.c0)),
    .valid_o(v3),
    .u_o    (),
    .sum_o  (num)
  );

  chse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(v3),
    .num_i  (num),
    .coef_i (coef),
    .err_i  (err),
    .valid_o(m_axis_tvalid),
    .y_o    (y),
    .sat_o  (sat),
    .err_o  (cerr)
  );

  assign m_axis_tdata = y;
  assign m_axis_tuser = {cerr, sat};

endmodule

// ===== design/chse_checker.sv =====
// Port-level checker for the Hermite segment evaluator, bound to the top level.
// Depends on cubic_hermite_segment_eval_assert.svh.
`include "cubic_hermite_segment_eval_assert.svh"

module chse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite
);

  // a bad segment yields a plain zero
  `CHSE_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == 32'h0 && !m_axis_tuser[0])

  // a clamped result sits at one of the two limits
  `CHSE_ASSERT_NOW(a_sat_limit, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000)

  // a register write restarts coefficient derivation and blocks queries
  `CHSE_ASSERT_NEXT(a_cfg_busy, psel && penable && pwrite, !s_axis_tready)

  // hold a stalled result
  `CHSE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind cubic_hermite_segment_eval chse_checker u_chse_checker (.*);
